[rtl/reversible_deque_with_drop_assert.svh]
// Assertion macros for the reversible deque.
// Each macro checks a property on the rising edge of clk_i; RDQ_ASSERT holds
// the check off while rst_ni is low.
`ifndef REVERSIBLE_DEQUE_WITH_DROP_ASSERT_SVH
`define REVERSIBLE_DEQUE_WITH_DROP_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on clk_i, disabled during reset.
`define RDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Same check, also active while in reset.
`define RDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RDQ_ASSERT(lbl, prop, msg)
`define RDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/rdq_pkg.sv]
`default_nettype none

package rdq_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 11;

  // Operation codes carried by one input beat
  typedef enum logic [ModeW-1:0] {
    MODE_LOAD    = 3'd0,
    MODE_REVERSE = 3'd1,
    MODE_DROP    = 3'd2,
    MODE_TAKE    = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Result fields that travel with an operation through the pipeline
  typedef struct packed {
    status_e           status;
    logic              last;
    logic              take;
    logic [CountW-1:0] count;
  } result_t;

endpackage

`default_nettype wire

[rtl/reversible_deque_with_drop.sv]
// Channel | Dir | Signals                                       | Beat
// in      | in  | in_valid_i/in_ready_o, mode_i, value_i        | one operation
// out     | out | out_valid_o/out_ready_i, status_o,            | one result
//         |     | front_value_o, last_o, count_o                |
//
// One operation is accepted per cycle while in_ready_o is high; a result passes
// the result stage and then the output register before out_valid_o rises.
// Pointers and counts update at the accept edge, so the ring memory (one
// write port, one registered read port) sees at most one access per beat.
// A take reads the ring at accept; the read data lands with the result stage.
// While out stalls, the result stage absorbs one more beat, then in_ready_o
// drops and follows out_ready_i. Reset empties the queue; the ring is not
// cleared.
`default_nettype none

`include "reversible_deque_with_drop_assert.svh"

module reversible_deque_with_drop #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     in_valid_i,
  output logic                                          in_ready_o,
  input  wire logic [rdq_pkg::ModeW-1:0]                mode_i,
  input  wire logic signed [rdq_pkg::ValueW-1:0]        value_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_ready_i,
  output logic [rdq_pkg::StatusW-1:0]                   status_o,
  output logic signed [rdq_pkg::ValueW-1:0]             front_value_o,
  output logic                                          last_o,
  output logic [rdq_pkg::CountW-1:0]                    count_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;

  // Ring position: (a + b) mod DEPTH, both operands below DEPTH
  function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] a,
                                               input logic [IdxW-1:0] b);
    logic [SumW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SumW'(DEPTH)) begin
      s = s - SumW'(DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  // Ring store
  logic [rdq_pkg::ValueW-1:0] mem [DEPTH];
  logic [rdq_pkg::ValueW-1:0] rdata_q;
  logic                       wr_en, rd_en;
  logic [IdxW-1:0]            wr_addr, rd_addr;

  // Queue control state
  logic [IdxW-1:0] first_q, first_d;
  logic [CntW-1:0] held_q, held_d;
  logic            rev_q, rev_d;
  logic            failed_q, failed_d;

  // Result stage and output register
  logic                       s1_valid_q, s1_valid_d;
  rdq_pkg::result_t           s1_q, s1_d;
  logic                       out_valid_q, out_valid_d;
  rdq_pkg::result_t           out_q;
  logic [rdq_pkg::ValueW-1:0] out_front_q;

  logic            in_fire, s1_move;
  logic            full, empty;
  logic [IdxW-1:0] pos_back, pos_last, pos_prev, pos_next;
  rdq_pkg::mode_e  mode;

  assign mode    = rdq_pkg::mode_e'(mode_i);
  assign s1_move = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire = in_valid_i && in_ready_o;

  assign full  = (held_q == CntW'(DEPTH));
  assign empty = (held_q == '0);

  // Ring positions around the current window
  assign pos_back = ring_add(first_q, held_q[IdxW-1:0]);
  assign pos_last = ring_add(first_q, IdxW'(held_q - CntW'(1)));
  assign pos_next = ring_add(first_q, IdxW'(1));
  assign pos_prev = (first_q == '0) ? IdxW'(DEPTH - 1) : first_q - IdxW'(1);

  // Operation decode and state update
  always_comb begin
    logic take_ok;
    logic do_pop;
    rdq_pkg::status_e status;
    first_d  = first_q;
    held_d   = held_q;
    rev_d    = rev_q;
    failed_d = failed_q;
    wr_en    = 1'b0;
    wr_addr  = pos_back;
    rd_en    = 1'b0;
    rd_addr  = first_q;
    status   = rdq_pkg::ST_OK;
    take_ok  = 1'b0;
    do_pop   = 1'b0;

    if (in_fire) begin
      priority if (mode == rdq_pkg::MODE_CLEAR) begin
        held_d   = '0;
        first_d  = '0;
        failed_d = 1'b0;
      end else if (failed_q) begin
        status = rdq_pkg::ST_ERROR;
      end else begin
        unique case (mode)
          rdq_pkg::MODE_LOAD: begin
            if (full) begin
              status = rdq_pkg::ST_FULL;
            end else begin
              wr_en  = 1'b1;
              held_d = held_q + CntW'(1);
              if (rev_q) begin
                first_d = pos_prev;
                wr_addr = pos_prev;
              end
            end
          end
          rdq_pkg::MODE_REVERSE: begin
            rev_d = !rev_q;
          end
          rdq_pkg::MODE_DROP: begin
            if (empty) begin
              failed_d = 1'b1;
              status   = rdq_pkg::ST_ERROR;
            end else begin
              do_pop = 1'b1;
            end
          end
          rdq_pkg::MODE_TAKE: begin
            if (empty) begin
              status = rdq_pkg::ST_EMPTY;
            end else begin
              do_pop  = 1'b1;
              take_ok = 1'b1;
              rd_en   = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    // Remove the logical front
    if (do_pop) begin
      rd_addr = rev_q ? pos_last : first_q;
      if (!rev_q) begin
        first_d = pos_next;
      end
      held_d = held_q - CntW'(1);
      if (held_q == CntW'(1)) begin
        first_d = '0;
      end
    end

    s1_d.status = status;
    s1_d.take   = take_ok;
    s1_d.last   = take_ok && (held_q == CntW'(1));
    s1_d.count  = rdq_pkg::CountW'(held_d);
  end

  // Stage handshakes
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      held_q      <= '0;
      rev_q       <= 1'b0;
      failed_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      held_q      <= held_d;
      rev_q       <= rev_d;
      failed_q    <= failed_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q       <= s1_q;
      out_front_q <= s1_q.take ? rdata_q : '0;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign front_value_o = out_front_q;
  assign last_o        = out_q.last;
  assign count_o       = out_q.count;

  // Checks
  `RDQ_ASSERT_ALWAYS(a_empty_first_zero, (held_q == '0) |-> (first_q == '0), "empty queue with nonzero first index")
  `RDQ_ASSERT(a_count_bound, held_q <= CntW'(DEPTH), "held count above depth")
  `RDQ_ASSERT(a_last_empty, (out_valid_q && out_q.last) |-> (out_q.count == '0 && out_q.status == rdq_pkg::ST_OK), "last set on nonempty result")
  `RDQ_ASSERT(a_failed_frozen, (in_fire && failed_q && mode_i != rdq_pkg::MODE_CLEAR) |=> (failed_q && held_q == $past(held_q) && first_q == $past(first_q)), "state moved while failed")

endmodule

`default_nettype wire

[verif/tb_reversible_deque_with_drop.sv]
`timescale 1ns / 100ps

localparam int unsigned RingDepth = 1024;
localparam int unsigned ModeSpan  = 1 << rdq_pkg::ModeW;

// One expected result beat
typedef struct packed {
  rdq_pkg::status_e                  status;
  logic signed [rdq_pkg::ValueW-1:0] front;
  logic                              last;
  logic [rdq_pkg::CountW-1:0]        count;
} deque_result_t;

// Tracks the deque contents and checks result beats in order
class deque_scoreboard;
  logic [rdq_pkg::ValueW-1:0] ring [RingDepth];
  int unsigned       head;
  int unsigned       held;
  bit                rev;
  bit                failed;
  deque_result_t     pending_results[$];
  int unsigned       mismatches;
  int unsigned       results_seen;

  task report_mismatch(string what, longint got, longint want);
    if (mismatches < 30) begin
      $display("%0t: result %0d: %s: got %0d, expected %0d",
               $time, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // Removes the logical front; the deque must hold something
  function logic [rdq_pkg::ValueW-1:0] pop_front();
    logic [rdq_pkg::ValueW-1:0] word;
    if (rev) begin
      word = ring[(head + held - 1) % RingDepth];
    end else begin
      word = ring[head];
      head = (head + 1) % RingDepth;
    end
    held--;
    if (held == 0) head = 0;
    return word;
  endfunction

  // Applies one operation and returns the result it should give
  function deque_result_t apply_op(logic [rdq_pkg::ModeW-1:0] m,
                                   logic [rdq_pkg::ValueW-1:0] v);
    deque_result_t r;
    r.status = rdq_pkg::ST_OK;
    r.front  = '0;
    r.last   = 1'b0;
    if (m == rdq_pkg::MODE_CLEAR) begin
      held   = 0;
      head   = 0;
      failed = 1'b0;
    end else if (failed) begin
      r.status = rdq_pkg::ST_ERROR;
    end else begin
      case (m)
        rdq_pkg::MODE_LOAD: begin
          if (held >= RingDepth) begin
            r.status = rdq_pkg::ST_FULL;
          end else if (rev) begin
            head = (head + RingDepth - 1) % RingDepth;
            ring[head] = v;
            held++;
          end else begin
            ring[(head + held) % RingDepth] = v;
            held++;
          end
        end
        rdq_pkg::MODE_REVERSE: rev = !rev;
        rdq_pkg::MODE_DROP: begin
          if (held == 0) begin
            failed   = 1'b1;
            r.status = rdq_pkg::ST_ERROR;
          end else begin
            void'(pop_front());
          end
        end
        rdq_pkg::MODE_TAKE: begin
          if (held == 0) begin
            r.status = rdq_pkg::ST_EMPTY;
          end else begin
            r.front = pop_front();
            r.last  = (held == 0);
          end
        end
        default: ;
      endcase
    end
    r.count = held[rdq_pkg::CountW-1:0];
    return r;
  endfunction

  function void note_op(logic [rdq_pkg::ModeW-1:0] m, logic [rdq_pkg::ValueW-1:0] v);
    pending_results.push_back(apply_op(m, v));
  endfunction

  task check_result(logic [rdq_pkg::StatusW-1:0] status,
                    logic signed [rdq_pkg::ValueW-1:0] front,
                    logic last, logic [rdq_pkg::CountW-1:0] count);
    deque_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing expected", status, 0);
    end else begin
      want = pending_results.pop_front();
      if (status !== want.status) report_mismatch("status", status, want.status);
      if (front !== want.front) report_mismatch("front_value", front, want.front);
      if (last !== want.last) report_mismatch("last", last, want.last);
      if (count !== want.count) report_mismatch("count", count, want.count);
    end
    results_seen++;
  endtask
endclass

module tb_reversible_deque_with_drop;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RxHoldLen     = 300;
  localparam int unsigned DrainCycles   = 10;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic [rdq_pkg::ModeW-1:0]          mode_i      = rdq_pkg::MODE_LOAD;
  logic signed [rdq_pkg::ValueW-1:0]  value_i     = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [rdq_pkg::StatusW-1:0]        status_o;
  logic signed [rdq_pkg::ValueW-1:0]  front_value_o;
  logic                               last_o;
  logic [rdq_pkg::CountW-1:0]         count_o;

  deque_scoreboard sb;
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_idle_pct = 0;
  int unsigned     rx_hold_requests = 0;
  int unsigned     rx_hold_seen = 0;
  int unsigned     rx_hold_left = 0;
  int unsigned     quiet_cycles = 0;

  reversible_deque_with_drop #(
    .DEPTH(RingDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .front_value_o(front_value_o),
    .last_o       (last_o),
    .count_o      (count_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: random back-pressure, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (rx_hold_requests != rx_hold_seen) begin
      rx_hold_seen = rx_hold_requests;
      rx_hold_left = RxHoldLen;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Beat monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_op(mode_i, value_i);
      if (out_valid_o && out_ready_i) sb.check_result(status_o, front_value_o, last_o, count_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL reversible_deque_with_drop");
        $finish;
      end
    end
  end

  // Offers one operation and waits until it is taken
  task automatic send_op(logic [rdq_pkg::ModeW-1:0] m, logic [rdq_pkg::ValueW-1:0] v);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sends the operation, and counts it unless the sticky error swallows it
  task automatic issue(logic [rdq_pkg::ModeW-1:0] m, logic [rdq_pkg::ValueW-1:0] v,
                       inout int unsigned counted);
    if (!sb.failed || m == rdq_pkg::MODE_CLEAR) counted++;
    send_op(m, v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  function automatic logic [rdq_pkg::ValueW-1:0] random_word();
    case ($urandom_range(15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed sequences with random content, some noise
  task automatic run_random(int unsigned budget);
    int unsigned               done_items;
    int unsigned               kind;
    int unsigned               n;
    logic [rdq_pkg::ModeW-1:0] m;
    done_items = 0;
    while (done_items < budget) begin
      if (sb.failed && $urandom_range(9) < 7) begin
        issue(rdq_pkg::MODE_CLEAR, random_word(), done_items);
      end
      kind = $urandom_range(99);
      if (kind < 30) begin
        // burst of loads
        n = $urandom_range(1, 16);
        repeat (n) begin
          m = ($urandom_range(9) == 0) ? rdq_pkg::MODE_REVERSE : rdq_pkg::MODE_LOAD;
          issue(m, random_word(), done_items);
        end
      end else if (kind < 50) begin
        // drain from the front, ending on an empty take when short
        n = (sb.held < 20) ? sb.held + 1 : 20;
        repeat (n) begin
          m = (sb.held > 1 && $urandom_range(9) < 3) ? rdq_pkg::MODE_DROP
                                                     : rdq_pkg::MODE_TAKE;
          issue(m, random_word(), done_items);
        end
      end else if (kind < 70) begin
        // interleaved loads, direction flips and takes
        n = $urandom_range(4, 12);
        repeat (n) begin
          case ($urandom_range(2))
            0: m = rdq_pkg::MODE_LOAD;
            1: m = rdq_pkg::MODE_REVERSE;
            default: m = rdq_pkg::MODE_TAKE;
          endcase
          issue(m, random_word(), done_items);
        end
      end else if (kind < 85) begin
        // raw noise over every mode code
        n = $urandom_range(1, 6);
        repeat (n) begin
          issue(rdq_pkg::ModeW'($urandom_range(ModeSpan - 1)), random_word(), done_items);
        end
      end else if (kind < 93) begin
        // provoke the sticky error, poke it, then clear
        if (sb.held > 8) issue(rdq_pkg::MODE_CLEAR, random_word(), done_items);
        n = sb.held + 1;
        repeat (n) issue(rdq_pkg::MODE_DROP, random_word(), done_items);
        n = $urandom_range(1, 4);
        repeat (n) begin
          m = rdq_pkg::ModeW'($urandom_range(ModeSpan - 1));
          if (m == rdq_pkg::MODE_CLEAR) m = rdq_pkg::MODE_TAKE;
          issue(m, random_word(), done_items);
        end
        issue(rdq_pkg::MODE_CLEAR, random_word(), done_items);
      end else begin
        m = $urandom_range(1) ? rdq_pkg::MODE_CLEAR : rdq_pkg::MODE_REVERSE;
        issue(m, random_word(), done_items);
      end
    end
  endtask

  // Loads until the ring is full, hits the full refusal, then takes and flips
  task automatic fill_to_full();
    int unsigned               counted;
    logic [rdq_pkg::ModeW-1:0] m;
    counted = 0;
    issue(rdq_pkg::MODE_CLEAR, random_word(), counted);
    if ($urandom_range(1)) issue(rdq_pkg::MODE_REVERSE, random_word(), counted);
    while (sb.held < RingDepth) begin
      m = ($urandom_range(49) == 0) ? rdq_pkg::MODE_REVERSE : rdq_pkg::MODE_LOAD;
      issue(m, random_word(), counted);
    end
    repeat (3) issue(rdq_pkg::MODE_LOAD, random_word(), counted);
    repeat (30) begin
      m = ($urandom_range(3) == 0) ? rdq_pkg::MODE_REVERSE : rdq_pkg::MODE_TAKE;
      issue(m, random_word(), counted);
    end
  endtask

  initial begin
    int unsigned               counted;
    logic [rdq_pkg::ModeW-1:0] m;
    sb = new;
    counted = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: value extremes, both ends, empty cases, sticky error
    tx_idle_pct = 12;
    rx_idle_pct = 65;
    send_op(rdq_pkg::MODE_LOAD, 32'h7fff_ffff);
    send_op(rdq_pkg::MODE_LOAD, 32'h8000_0000);
    send_op(rdq_pkg::MODE_LOAD, 32'hffff_ffff);
    send_op(rdq_pkg::MODE_LOAD, 32'h0000_0000);
    send_op(rdq_pkg::MODE_TAKE, '0);
    send_op(rdq_pkg::MODE_REVERSE, '0);
    send_op(rdq_pkg::MODE_TAKE, '0);
    send_op(rdq_pkg::MODE_LOAD, 32'h5555_5555);
    send_op(rdq_pkg::MODE_DROP, '0);
    send_op(rdq_pkg::MODE_TAKE, '0);
    send_op(rdq_pkg::MODE_TAKE, '0);
    send_op(rdq_pkg::MODE_TAKE, '0);
    send_op(rdq_pkg::MODE_DROP, '0);
    send_op(rdq_pkg::MODE_LOAD, 32'h1234_5678);
    send_op(rdq_pkg::MODE_REVERSE, '0);
    for (m = rdq_pkg::ModeW'(rdq_pkg::MODE_CLEAR + 1); m != 0; m++) send_op(m, '1);
    send_op(rdq_pkg::MODE_TAKE, '0);
    send_op(rdq_pkg::MODE_CLEAR, '0);
    for (m = rdq_pkg::ModeW'(rdq_pkg::MODE_CLEAR + 1); m != 0; m++) send_op(m, '0);
    send_op(rdq_pkg::MODE_LOAD, 32'haaaa_aaaa);
    send_op(rdq_pkg::MODE_TAKE, '0);
    wait_drained();

    // Random phases with shifting idle patterns
    run_random(40);
    wait_drained();
    tx_idle_pct = 65;
    rx_idle_pct = 12;
    run_random(40);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fill_to_full();
    rx_hold_requests++;
    run_random(40);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      sb.report_mismatch("results never arrived", 0, sb.pending_results.size());
    end
    if (sb.mismatches == 0) begin
      $display("PASS reversible_deque_with_drop");
    end else begin
      $display("FAIL reversible_deque_with_drop");
    end
    $finish;
  end

endmodule
